>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Small set of concurrent assertion macros shared by the rtl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/nsqrt_pkg.sv
// ----------------------------------------------------------------------------
// nsqrt_pkg
// Shared constants and types for the fixed-step Newton square root.
// ----------------------------------------------------------------------------
package nsqrt_pkg;

  // number format and step count
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ITERATIONS = 8;

  // derived widths
  localparam int unsigned ITER_W = $clog2(ITERATIONS + 1);
  localparam int unsigned NUM_W  = WORD_W + FRAC_BITS + 1;
  localparam int unsigned DIV_W  = WORD_W + 1;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] ONE_FIXED = WORD_W'(1) << FRAC_BITS;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/nsqrt_div.sv
// ----------------------------------------------------------------------------
// nsqrt_div
// Restoring divider, one quotient bit per cycle, WORD_W-bit quotient.
// The caller guarantees the top NUM_W-WORD_W dividend bits are below the
// divisor, so the quotient fits in WORD_W bits.
// ----------------------------------------------------------------------------
module nsqrt_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [nsqrt_pkg::NUM_W-1:0]        dividend_i,
  input  logic [nsqrt_pkg::DIV_W-1:0]        divisor_i,
  output nsqrt_pkg::div_status_t             status_o,
  output logic [nsqrt_pkg::WORD_W-1:0]       quotient_o
);

  localparam int unsigned HI_W = nsqrt_pkg::NUM_W - nsqrt_pkg::WORD_W;

  logic [nsqrt_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [nsqrt_pkg::WORD_W-1:0] quot_q, quot_d;
  logic [nsqrt_pkg::DIV_W-1:0]  div_q;
  logic [nsqrt_pkg::CNT_W-1:0]  cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [nsqrt_pkg::DIV_W:0]    trial;
  logic [nsqrt_pkg::DIV_W:0]    diff;
  logic                         qbit;
  logic                         last_bit;

  // one trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, quot_q[nsqrt_pkg::WORD_W-1]};
    diff   = trial - {1'b0, div_q};
    qbit   = (trial >= {1'b0, div_q});
    rem_d  = qbit ? diff[nsqrt_pkg::DIV_W-1:0] : trial[nsqrt_pkg::DIV_W-1:0];
    quot_d = {quot_q[nsqrt_pkg::WORD_W-2:0], qbit};
  end

  assign last_bit = (cnt_q == nsqrt_pkg::CNT_W'(nsqrt_pkg::WORD_W - 1));

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= nsqrt_pkg::DIV_W'(dividend_i[nsqrt_pkg::NUM_W-1 -: HI_W]);
      quot_q <= dividend_i[nsqrt_pkg::WORD_W-1:0];
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  // bit counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && last_bit;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quot_q;

endmodule

>>> rtl/newton_square_root_fixed_iterations_core.sv
// ----------------------------------------------------------------------------
// newton_square_root_fixed_iterations_core
// Unsigned fixed-point square root by up to a fixed number of Newton steps.
// ----------------------------------------------------------------------------
// channel  signals                          direction  payload
// in       in_valid_i / in_ready_o          input      radicand_i (32 bit)
// out      out_valid_o / out_ready_i        output     root_o (32 bit)
//
// each step runs the check state, then a division in the shared restoring
// divider; a result is valid after at most ITERATIONS (8) steps, and the next
// transaction can be taken in the same cycle that the result becomes valid.
// a radicand below one finishes with no division.
// in_ready_o is high whenever the sequencer is idle, even while a result
// waits in the output register; a stalled output holds the sequencer in its
// finish state. reset clears control state only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newton_square_root_fixed_iterations_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nsqrt_pkg::WORD_W-1:0] radicand_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [nsqrt_pkg::WORD_W-1:0] root_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e                          state_q;
  logic [nsqrt_pkg::WORD_W-1:0]    t_q;
  logic [nsqrt_pkg::WORD_W-1:0]    x_q;
  logic [nsqrt_pkg::ITER_W-1:0]    iter_q;
  logic                            out_valid_q;
  logic [nsqrt_pkg::WORD_W-1:0]    root_q;

  logic                            div_start;
  logic [nsqrt_pkg::NUM_W-1:0]     dividend;
  logic [nsqrt_pkg::DIV_W-1:0]     divisor;
  nsqrt_pkg::div_status_t          div_status;
  logic [nsqrt_pkg::WORD_W-1:0]    quotient;
  logic [nsqrt_pkg::WORD_W:0]      step_sum;
  logic [nsqrt_pkg::WORD_W-1:0]    step_sat;
  logic                            stop;
  logic                            in_fire;
  logic                            slot_free;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // steps end once the estimate is below one or the count runs out
  assign stop = (t_q < nsqrt_pkg::ONE_FIXED) ||
                (iter_q == nsqrt_pkg::ITER_W'(nsqrt_pkg::ITERATIONS));

  // step operands: odd part of t plus x scaled, over 2t
  assign div_start = (state_q == ST_CHECK) && !stop;
  assign dividend  = nsqrt_pkg::NUM_W'(t_q[0] ? t_q : '0) +
                     (nsqrt_pkg::NUM_W'(x_q) << nsqrt_pkg::FRAC_BITS);
  assign divisor   = {t_q, 1'b0};

  // half of t plus quotient, saturated to the word
  assign step_sum = nsqrt_pkg::DIV_W'(t_q >> 1) + nsqrt_pkg::DIV_W'(quotient);
  assign step_sat = step_sum[nsqrt_pkg::WORD_W] ? '1 : step_sum[nsqrt_pkg::WORD_W-1:0];

  nsqrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register refills from the finish state or empties on acceptance
      if ((state_q == ST_FINISH) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            iter_q  <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stop) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            iter_q  <= iter_q + 1'b1;
            state_q <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= radicand_i;
      t_q <= radicand_i;
    end else if ((state_q == ST_DIV) && div_status.done) begin
      t_q <= step_sat;
    end
    if ((state_q == ST_FINISH) && slot_free) begin
      root_q <= t_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

  // checks
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o)
  `ASSERT_IMP(a_iter_bound, clk_i, rst_ni, 1'b1,
              iter_q <= nsqrt_pkg::ITER_W'(nsqrt_pkg::ITERATIONS))
  `ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, div_status.busy || div_status.done,
              state_q == ST_DIV)
  `ASSERT_NEXT(a_start_needs_one, clk_i, rst_ni, div_start, div_status.busy)

endmodule
